FILE: rtl/cfps_pkg.sv
package cfps_pkg;

  // Field and fixed-point widths of the smoothed level.
  localparam int DIST_BITS   = 12;
  localparam int FRAC_BITS   = 8;
  localparam int LEVEL_W     = DIST_BITS + FRAC_BITS;
  localparam int CFG_W       = 12;
  localparam int CFG_IDX_W   = 2;
  localparam int PHASE_W     = 3;
  localparam int SPIKE_LIMIT = 5;

  // Filter weights: about 0.7 on the old level, 0.3 on the sample, over 256.
  localparam int KEEP_W    = 179;
  localparam int NEW_W     = 77;
  localparam int WGT_SHIFT = 8;
  localparam int PROD_W    = LEVEL_W + WGT_SHIFT + 1;

  // Width in which a register or distance is compared after alignment.
  localparam int INT_W = (CFG_W > DIST_BITS) ? CFG_W : DIST_BITS;
  localparam int CMP_W = INT_W + FRAC_BITS;

  typedef logic [DIST_BITS-1:0] dist_t;
  typedef logic [LEVEL_W-1:0]   level_t;
  typedef logic [CFG_W-1:0]     cfg_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic [PHASE_W-1:0]   phase_code_t;
  typedef logic [CMP_W-1:0]     cmp_t;

  // Configuration register indexes.
  localparam cfg_idx_t CFG_EMPTY_CUP   = 2'd0;
  localparam cfg_idx_t CFG_FULL_LEVEL  = 2'd1;
  localparam cfg_idx_t CFG_SYRUP_SWTCH = 2'd2;

  localparam cfg_t EMPTY_CUP_RST   = cfg_t'(90);
  localparam cfg_t FULL_LEVEL_RST  = cfg_t'(30);
  localparam cfg_t SYRUP_SWTCH_RST = cfg_t'(75);

  // Phase codes as they appear on the result channel.
  localparam phase_code_t PHC_START     = 3'd0;
  localparam phase_code_t PHC_NO_CUP    = 3'd1;
  localparam phase_code_t PHC_WAIT_CUP  = 3'd2;
  localparam phase_code_t PHC_CUP       = 3'd3;
  localparam phase_code_t PHC_WAIT_KEY  = 3'd4;
  localparam phase_code_t PHC_MIXING    = 3'd5;
  localparam phase_code_t PHC_DONE      = 3'd6;
  localparam phase_code_t PHC_UNUSED    = 3'd7;

  typedef enum logic [6:0] {
    PH_START    = 7'b0000001,
    PH_NO_CUP   = 7'b0000010,
    PH_WAIT_CUP = 7'b0000100,
    PH_CUP      = 7'b0001000,
    PH_WAIT_KEY = 7'b0010000,
    PH_MIXING   = 7'b0100000,
    PH_DONE     = 7'b1000000
  } phase_t;

  // Control state handed between the phase logic and the top level.
  typedef struct packed {
    phase_t phase;
    logic   led;
    logic   syrup;
    logic   water;
  } ctrl_t;

  function automatic phase_code_t phase_code(phase_t ph);
    phase_code_t code;
    case (ph)
      PH_START:    code = PHC_START;
      PH_NO_CUP:   code = PHC_NO_CUP;
      PH_WAIT_CUP: code = PHC_WAIT_CUP;
      PH_CUP:      code = PHC_CUP;
      PH_WAIT_KEY: code = PHC_WAIT_KEY;
      PH_MIXING:   code = PHC_MIXING;
      PH_DONE:     code = PHC_DONE;
      default:     code = PHC_UNUSED;
    endcase
    return code;
  endfunction

  // Register value aligned to the fixed point of the level.
  function automatic cmp_t cfg_fx(cfg_t v);
    return cmp_t'(v) << FRAC_BITS;
  endfunction

  function automatic cmp_t level_cmp(level_t v);
    return cmp_t'(v);
  endfunction

endpackage

FILE: rtl/cfps_in_if.sv
interface cfps_in_if;
  logic               valid;
  logic               ready;
  logic               cup_seen;
  logic               key_pressed;
  cfps_pkg::dist_t    distance_mm;

  modport source (output valid, output cup_seen, output key_pressed,
                  output distance_mm, input ready);
  modport sink   (input valid, input cup_seen, input key_pressed,
                  input distance_mm, output ready);
endinterface

FILE: rtl/cfps_out_if.sv
interface cfps_out_if;
  logic                   valid;
  logic                   ready;
  logic                   green_led;
  logic                   syrup_pump;
  logic                   water_motor;
  logic                   syrup_valve;
  logic                   water_gate;
  cfps_pkg::phase_code_t  phase;
  cfps_pkg::dist_t        fill_level_mm;

  modport source (output valid, output green_led, output syrup_pump,
                  output water_motor, output syrup_valve, output water_gate,
                  output phase, output fill_level_mm, input ready);
  modport sink   (input valid, input green_led, input syrup_pump,
                  input water_motor, input syrup_valve, input water_gate,
                  input phase, input fill_level_mm, output ready);
endinterface

FILE: rtl/cfps_filter.sv
module cfps_filter (
  input  cfps_pkg::level_t level,
  input  cfps_pkg::dist_t  distance_mm,
  input  cfps_pkg::cfg_t   empty_cup_mm,
  output cfps_pkg::level_t level_nxt
);
  import cfps_pkg::*;

  localparam level_t SPIKE_FX = level_t'(SPIKE_LIMIT << FRAC_BITS);

  dist_t               sample;
  level_t              sample_fx;
  level_t              diff;
  logic [PROD_W-1:0]   acc;

  // Clamp the reading to the empty-cup distance.
  always_comb begin
    if (INT_W'(distance_mm) > INT_W'(empty_cup_mm)) begin
      sample = dist_t'(empty_cup_mm);
    end else begin
      sample = distance_mm;
    end
  end

  assign sample_fx = level_t'(sample) << FRAC_BITS;
  assign diff      = level - sample_fx;

  // Weighted blend of old level and sample, constant coefficients.
  assign acc = PROD_W'(KEEP_W) * PROD_W'(level) + PROD_W'(NEW_W) * PROD_W'(sample_fx);

  // A sample above the level or far below it is a spike and is dropped.
  always_comb begin
    if ((sample_fx > level) || (diff > SPIKE_FX)) begin
      level_nxt = level;
    end else begin
      level_nxt = acc[WGT_SHIFT +: LEVEL_W];
    end
  end

endmodule

FILE: rtl/cfps_phase.sv
module cfps_phase (
  input  cfps_pkg::ctrl_t  cur,
  input  logic             cup,
  input  logic             key,
  input  cfps_pkg::dist_t  distance_mm,
  input  cfps_pkg::level_t level_filt,
  input  cfps_pkg::cfg_t   full_level_mm,
  input  cfps_pkg::cfg_t   syrup_switch_mm,
  output cfps_pkg::ctrl_t  nxt,
  output cfps_pkg::level_t level_nxt
);
  import cfps_pkg::*;

  // The phase steps are applied in order within one tick; later steps see
  // the phase that earlier steps left.
  always_comb begin
    ctrl_t  c;
    level_t lvl;
    c   = cur;
    lvl = level_filt;

    if (c.phase == PH_START) begin
      c.phase = cup ? PH_CUP : PH_NO_CUP;
    end
    if (!cup) begin
      c.phase = PH_NO_CUP;
    end
    if (c.phase == PH_CUP) begin
      c.phase = PH_WAIT_KEY;
      c.led   = 1'b1;
    end
    if (c.phase == PH_NO_CUP) begin
      c.phase = PH_WAIT_CUP;
      c.led   = 1'b0;
      c.syrup = 1'b0;
      c.water = 1'b0;
    end
    if ((c.phase == PH_WAIT_CUP) && cup) begin
      c.phase = PH_CUP;
    end
    // A key press loads the raw reading and starts mixing at once.
    if ((c.phase == PH_WAIT_KEY) && key) begin
      lvl     = level_t'(distance_mm) << FRAC_BITS;
      c.phase = PH_MIXING;
    end
    if (c.phase == PH_MIXING) begin
      if (level_cmp(lvl) < cfg_fx(full_level_mm)) begin
        c.phase = PH_DONE;
        c.syrup = 1'b0;
        c.water = 1'b0;
      end else if (level_cmp(lvl) > cfg_fx(syrup_switch_mm)) begin
        c.syrup = 1'b1;
        c.water = 1'b0;
      end else begin
        c.syrup = 1'b0;
        c.water = 1'b1;
      end
    end

    nxt       = c;
    level_nxt = lvl;
  end

endmodule

FILE: rtl/cup_fill_pump_sequencer.sv
// Cup fill pump sequencer. Each input item is one sensor tick and yields
// exactly one result item; a new item is taken in every cycle while the
// result slot is empty or being read, so the sustained rate is one item
// per clock. A tick runs one step of the spike rejecting level filter, then
// the phase machine that drives the green LED, the pumps and their valves;
// the result shows the state after the tick. Registers are written through
// the cfg port (index 0 empty cup distance, 1 full level, 2 syrup switch
// level) by the user only with no item in flight; the block does not check.
module cup_fill_pump_sequencer (
  input  logic                clk,
  input  logic                rst_n,
  cfps_in_if.sink             in_if,
  cfps_out_if.source          out_if,
  input  logic                cfg_we,
  input  cfps_pkg::cfg_idx_t  cfg_index,
  input  cfps_pkg::cfg_t      cfg_data
);
  import cfps_pkg::*;

  cfg_t   empty_cup_r, full_level_r, syrup_switch_r;
  ctrl_t  ctrl_r, ctrl_nxt;
  level_t level_r, level_filt, level_nxt;
  logic   out_valid_r;
  logic   in_fire;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      empty_cup_r    <= EMPTY_CUP_RST;
      full_level_r   <= FULL_LEVEL_RST;
      syrup_switch_r <= SYRUP_SWTCH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_EMPTY_CUP:   empty_cup_r    <= cfg_data;
        CFG_FULL_LEVEL:  full_level_r   <= cfg_data;
        CFG_SYRUP_SWTCH: syrup_switch_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // State changes only when the result slot is free, so the state registers
  // double as the result payload.
  assign in_if.ready = !out_valid_r || out_if.ready;
  assign in_fire     = in_if.valid && in_if.ready;

  cfps_filter u_filter (
    .level        (level_r),
    .distance_mm  (in_if.distance_mm),
    .empty_cup_mm (empty_cup_r),
    .level_nxt    (level_filt)
  );

  cfps_phase u_phase (
    .cur             (ctrl_r),
    .cup             (in_if.cup_seen),
    .key             (in_if.key_pressed),
    .distance_mm     (in_if.distance_mm),
    .level_filt      (level_filt),
    .full_level_mm   (full_level_r),
    .syrup_switch_mm (syrup_switch_r),
    .nxt             (ctrl_nxt),
    .level_nxt       (level_nxt)
  );

  // Tick state and result valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r      <= '{phase: PH_START, led: 1'b0, syrup: 1'b0, water: 1'b0};
      level_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        ctrl_r  <= ctrl_nxt;
        level_r <= level_nxt;
      end
      if (in_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload.
  assign out_if.valid         = out_valid_r;
  assign out_if.green_led     = ctrl_r.led;
  assign out_if.syrup_pump    = ctrl_r.syrup;
  assign out_if.water_motor   = ctrl_r.water;
  assign out_if.syrup_valve   = !ctrl_r.syrup;
  assign out_if.water_gate    = !ctrl_r.water;
  assign out_if.phase         = phase_code(ctrl_r.phase);
  assign out_if.fill_level_mm = level_r[FRAC_BITS +: DIST_BITS];

  // Both pumps never run together.
  a_pumps_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctrl_r.syrup && ctrl_r.water))
    else $error("syrup and water pumps on together");

  // A pump runs only while mixing.
  a_pump_only_mixing: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl_r.syrup || ctrl_r.water) |-> (ctrl_r.phase == PH_MIXING))
    else $error("pump on outside mixing");

  // Mixing and done always have the ready LED lit.
  a_led_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ((ctrl_r.phase == PH_MIXING) || (ctrl_r.phase == PH_DONE)) |-> ctrl_r.led)
    else $error("LED off while mixing or done");

  // A tick without a cup always lands in wait cup.
  a_no_cup_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !in_if.cup_seen) |=> (ctrl_r.phase == PH_WAIT_CUP))
    else $error("cup removal did not lead to wait cup");

  // State holds while a result waits to be taken.
  a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_if.ready) |=> ($stable(ctrl_r) && $stable(level_r)))
    else $error("state changed under a stalled result");

endmodule
